// ===== sv/modular_exponentiation_top_macros.svh =====
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define MODEXP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("modexp assertion failed");

// next-cycle implication, checked out of reset
`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("modexp assertion failed");

`endif

// ===== sv/modexp_pkg.sv =====
// shared constants and types for the modular exponentiation block
package modexp_pkg;

	localparam int BASE_W = 32;
	localparam logic [31:0] MOD_RESET = 32'd104060401;

	typedef struct packed {
		logic start;
		logic reduce_only;
	} modexp_mul_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} modexp_mul_sts_t;

endpackage

// ===== sv/modexp_ifs.sv =====
// request and result channel interfaces for the modular exponentiation block
interface modexp_req_if import modexp_pkg::*; #(
	parameter int EXP_WIDTH = 60
);
	logic                 valid;
	logic                 ready;
	logic [BASE_W-1:0]    base_value;
	logic [EXP_WIDTH-1:0] exponent;

	modport source (output valid, output base_value, output exponent, input ready);
	modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface modexp_rsp_if #(
	parameter int MOD_WIDTH = 27
);
	logic                 valid;
	logic                 ready;
	logic [MOD_WIDTH-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

// ===== sv/modexp_modmul.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module modexp_modmul import modexp_pkg::*; #(
	parameter int MOD_WIDTH = 27,
	parameter int OP_W      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  modexp_mul_cmd_t      cmd,
	input  logic [MOD_WIDTH-1:0] multiplicand,
	input  logic [OP_W-1:0]      multiplier,
	input  logic [MOD_WIDTH-1:0] modulus,
	output modexp_mul_sts_t      sts,
	output logic [MOD_WIDTH-1:0] product
);

	localparam int CNT_W = $clog2(OP_W);
	localparam int ACC_W = MOD_WIDTH + 2;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [OP_W-1:0]      mpr_q;
	logic [MOD_WIDTH-1:0] mcand_q;
	logic                 reduce_q;

	logic [CNT_W-1:0] steps;
	logic [ACC_W-1:0] addend;
	logic [ACC_W-1:0] sum;
	logic [ACC_W-1:0] mod_x1;
	logic [ACC_W-1:0] mod_x2;
	logic [ACC_W-1:0] acc_d;

	assign steps  = cmd.reduce_only ? CNT_W'(BASE_W - 1) : CNT_W'(MOD_WIDTH - 1);
	assign addend = reduce_q ? ACC_W'(1) : ACC_W'(mcand_q);
	assign sum    = {1'b0, acc_q, 1'b0} + (mpr_q[OP_W-1] ? addend : '0);
	assign mod_x1 = ACC_W'(modulus);
	assign mod_x2 = {1'b0, modulus, 1'b0};

	always_comb begin
		if (sum >= mod_x2) begin
			acc_d = sum - mod_x2;
		end else if (sum >= mod_x1) begin
			acc_d = sum - mod_x1;
		end else begin
			acc_d = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q    <= '0;
			mpr_q    <= multiplier;
			mcand_q  <= multiplicand;
			reduce_q <= cmd.reduce_only;
		end else if (busy_q) begin
			acc_q <= acc_d[MOD_WIDTH-1:0];
			mpr_q <= mpr_q << 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

// ===== sv/modular_exponentiation_top.sv =====
// first the base is reduced modulo the modulus, then the exponent bits are scanned up to the leading one
// each later bit: a square, plus a multiply when it is set; a modulus below 2 gives a zero result
// one request at a time, paced by the single bit-serial modular multiplier
// a finished result waits in the output register while the next request is taken
// reset clears the sequencer and the output valid and loads the modulus with 101^4
`include "modular_exponentiation_top_macros.svh"
module modular_exponentiation_top import modexp_pkg::*; #(
	parameter int EXP_WIDTH = 60,
	parameter int MOD_WIDTH = 27
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 modulus_wr_en,
	input  logic [MOD_WIDTH-1:0] modulus_wr_data,
	modexp_req_if.sink           req,
	modexp_rsp_if.source         rsp
);

	localparam int OP_W  = (MOD_WIDTH > BASE_W) ? MOD_WIDTH : BASE_W;
	localparam int IDX_W = $clog2(EXP_WIDTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BASE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]           state_q;
	logic [MOD_WIDTH-1:0] modulus_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 started_q;
	logic [MOD_WIDTH-1:0] r_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0] power_q;
	logic                 rsp_valid_q;

	modexp_mul_cmd_t      mul_cmd;
	modexp_mul_sts_t      mul_sts;
	logic [MOD_WIDTH-1:0] mul_mcand;
	logic [OP_W-1:0]      mul_mpr;
	logic [MOD_WIDTH-1:0] mul_prod;

	logic accept;
	logic mod_ok;
	logic cur_bit;
	logic last_bit;
	logic out_free;

	assign accept   = req.valid && req.ready;
	assign mod_ok   = modulus_q >= MOD_WIDTH'(2);
	assign cur_bit  = exp_q[EXP_WIDTH-1];
	assign last_bit = idx_q == '0;
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		mul_cmd   = '0;
		mul_mcand = r_q;
		mul_mpr   = OP_W'(r_q) << (OP_W - MOD_WIDTH);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mod_ok) begin
					mul_cmd.start       = 1'b1;
					mul_cmd.reduce_only = 1'b1;
					mul_mpr             = OP_W'(req.base_value) << (OP_W - BASE_W);
				end
			end
			ST_SCAN: begin
				mul_cmd.start = started_q;
			end
			ST_SQR: begin
				if (mul_sts.done && cur_bit) begin
					mul_cmd.start = 1'b1;
					mul_mcand     = b_q;
					mul_mpr       = OP_W'(mul_prod) << (OP_W - MOD_WIDTH);
				end
			end
			default: begin
			end
		endcase
	end

	modexp_modmul #(
		.MOD_WIDTH (MOD_WIDTH),
		.OP_W      (OP_W)
	) u_modmul (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (mul_cmd),
		.multiplicand (mul_mcand),
		.multiplier   (mul_mpr),
		.modulus      (modulus_q),
		.sts          (mul_sts),
		.product      (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET[MOD_WIDTH-1:0];
		end else if (modulus_wr_en) begin
			modulus_q <= modulus_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			idx_q       <= '0;
			started_q   <= 1'b0;
			r_q         <= '0;
			b_q         <= '0;
			power_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						exp_q     <= req.exponent;
						idx_q     <= IDX_W'(EXP_WIDTH - 1);
						started_q <= 1'b0;
						if (mod_ok) begin
							r_q     <= MOD_WIDTH'(1);
							state_q <= ST_BASE;
						end else begin
							r_q     <= '0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_BASE: begin
					if (mul_sts.done) begin
						b_q     <= mul_prod;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (started_q) begin
						state_q <= ST_SQR;
					end else begin
						if (cur_bit) begin
							r_q       <= b_q;
							started_q <= 1'b1;
						end
						exp_q   <= exp_q << 1;
						idx_q   <= idx_q - 1'b1;
						state_q <= last_bit ? ST_FIN : ST_SCAN;
					end
				end
				ST_SQR: begin
					if (mul_sts.done) begin
						r_q <= mul_prod;
						if (cur_bit) begin
							state_q <= ST_MUL;
						end else begin
							exp_q   <= exp_q << 1;
							idx_q   <= idx_q - 1'b1;
							state_q <= last_bit ? ST_FIN : ST_SCAN;
						end
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						r_q     <= mul_prod;
						exp_q   <= exp_q << 1;
						idx_q   <= idx_q - 1'b1;
						state_q <= last_bit ? ST_FIN : ST_SCAN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						power_q     <= r_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = state_q == ST_IDLE;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.power_result = power_q;

	`MODEXP_ASSERT_IMPL(a_idle_unit_quiet, clk, arst_n, state_q == ST_IDLE, !mul_sts.busy)
	`MODEXP_ASSERT_IMPL(a_done_in_wait, clk, arst_n, mul_sts.done,
		state_q == ST_BASE || state_q == ST_SQR || state_q == ST_MUL)
	`MODEXP_ASSERT_NEXT(a_small_mod_skip, clk, arst_n, accept && !mod_ok, state_q == ST_FIN)
	`MODEXP_ASSERT_IMPL(a_result_reduced, clk, arst_n, rsp_valid_q && mod_ok, power_q < modulus_q)

endmodule
